// ===== src/jsof_pkg.sv =====
package jsof_pkg;

  // Default width of the running byte counter.
  localparam int unsigned POSITION_BITS_DEF = 24;

  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned OFFSET_W = 24;

  // Marker bytes.
  localparam logic [7:0] MK_FF    = 8'hff;
  localparam logic [7:0] MK_SOI   = 8'hd8;
  localparam logic [7:0] MK_RST0  = 8'hd0;
  localparam logic [7:0] MK_RST7  = 8'hd7;
  localparam logic [7:0] MK_SOS   = 8'hda;
  localparam logic [7:0] MK_EOI   = 8'hd9;
  localparam logic [7:0] MK_SOF0  = 8'hc0;
  localparam logic [7:0] MK_SOF1  = 8'hc1;
  localparam logic [7:0] MK_SOF2  = 8'hc2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [HEIGHT_W-1:0] frame_height;
    logic [OFFSET_W-1:0] height_offset;
  } out_t;

  typedef enum logic [11:0] {
    PH_SOI_FF     = 12'h001,
    PH_SOI_D8     = 12'h002,
    PH_MARK_FF    = 12'h004,
    PH_MARK_CODE  = 12'h008,
    PH_LEN_HI     = 12'h010,
    PH_LEN_LO     = 12'h020,
    PH_SKIP       = 12'h040,
    PH_SOF_LEN_HI = 12'h080,
    PH_SOF_LEN_LO = 12'h100,
    PH_SOF_PREC   = 12'h200,
    PH_SOF_HT_HI  = 12'h400,
    PH_SOF_HT_LO  = 12'h800
  } phase_t;

endpackage

// ===== src/jpeg_sof_height_finder.sv =====
// JPEG SOF height finder. Feed the bytes of one JPEG buffer in order, one per
// transaction, with last_byte set on the final byte. The buffer must open with
// FF D8; marker segments are then walked (FF fill skipped, SOI/RST0..7 stand
// alone, everything else skipped by its 16-bit length). At the first SOF0,
// SOF1 or SOF2 one result transaction reports found=1, the big-endian height
// and the byte offset of the height's first byte. SOS, EOI, a stray non-FF
// byte where a marker belongs, a segment length below 2, or the buffer ending
// first gives one result with found=0 and zero fields. At most one result per
// buffer; the rest of the buffer is swallowed and the block re-arms after the
// last byte. Throughput is one byte per clock: the parser state updates on each
// accepted byte and the result lands in an output register, so in_stall only
// rises while a result sits in that register and the consumer holds out_stall.
// out_valid rises in the cycle after the deciding byte is accepted. The byte
// counter is POSITION_BITS wide and wraps; the reported offset is that count
// cut or zero-extended to 24 bits.
module jpeg_sof_height_finder #(
  parameter int unsigned POSITION_BITS = jsof_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  jsof_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output jsof_pkg::out_t out_data
);

  // Parser state
  jsof_pkg::phase_t   phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]        skip_r, skip_nxt;
  logic [7:0]         hup_r, hup_nxt;
  logic               decided_r, decided_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  jsof_pkg::out_t     out_data_r, out_data_nxt;

  logic               in_fire;
  logic               res_valid;
  jsof_pkg::out_t     res;
  logic [7:0]         b;
  logic [15:0]        seg_len;
  logic [15:0]        skip_dec;
  logic [POSITION_BITS-1:0] off_full;
  logic [31:0]        off_ext;

  // A new byte can enter whenever the output slot is free or being drained.
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b        = in_data.byte_value;
  assign seg_len  = {skip_r[7:0], b};
  assign skip_dec = (skip_r != 16'd0) ? skip_r - 16'd1 : skip_r;
  assign off_full = pos_r - POSITION_BITS'(1);
  assign off_ext  = 32'(off_full);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r + POSITION_BITS'(1);
    skip_nxt    = skip_r;
    hup_nxt     = hup_r;
    decided_nxt = decided_r;
    res_valid   = 1'b0;
    res         = '0;

    if (!decided_r) begin
      unique case (phase_r)
        jsof_pkg::PH_SOI_FF: begin
          if (b == jsof_pkg::MK_FF) phase_nxt = jsof_pkg::PH_SOI_D8;
          else res_valid = 1'b1;
        end
        jsof_pkg::PH_SOI_D8: begin
          if (b == jsof_pkg::MK_SOI) phase_nxt = jsof_pkg::PH_MARK_FF;
          else res_valid = 1'b1;
        end
        jsof_pkg::PH_MARK_FF: begin
          if (b == jsof_pkg::MK_FF) phase_nxt = jsof_pkg::PH_MARK_CODE;
          else res_valid = 1'b1;
        end
        jsof_pkg::PH_MARK_CODE: begin
          priority if (b == jsof_pkg::MK_FF) begin
            // fill byte, stay
          end else if (b == jsof_pkg::MK_SOI ||
                       (b >= jsof_pkg::MK_RST0 && b <= jsof_pkg::MK_RST7)) begin
            phase_nxt = jsof_pkg::PH_MARK_FF;
          end else if (b == jsof_pkg::MK_SOS || b == jsof_pkg::MK_EOI) begin
            res_valid = 1'b1;
          end else if (b == jsof_pkg::MK_SOF0 || b == jsof_pkg::MK_SOF1 ||
                       b == jsof_pkg::MK_SOF2) begin
            phase_nxt = jsof_pkg::PH_SOF_LEN_HI;
          end else begin
            phase_nxt = jsof_pkg::PH_LEN_HI;
          end
        end
        jsof_pkg::PH_LEN_HI: begin
          skip_nxt  = {8'd0, b};
          phase_nxt = jsof_pkg::PH_LEN_LO;
        end
        jsof_pkg::PH_LEN_LO: begin
          if (seg_len < 16'd2) begin
            res_valid = 1'b1;
          end else begin
            skip_nxt  = seg_len - 16'd2;
            phase_nxt = (seg_len == 16'd2) ? jsof_pkg::PH_MARK_FF : jsof_pkg::PH_SKIP;
          end
        end
        jsof_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) phase_nxt = jsof_pkg::PH_MARK_FF;
        end
        jsof_pkg::PH_SOF_LEN_HI: phase_nxt = jsof_pkg::PH_SOF_LEN_LO;
        jsof_pkg::PH_SOF_LEN_LO: phase_nxt = jsof_pkg::PH_SOF_PREC;
        jsof_pkg::PH_SOF_PREC:   phase_nxt = jsof_pkg::PH_SOF_HT_HI;
        jsof_pkg::PH_SOF_HT_HI: begin
          hup_nxt   = b;
          phase_nxt = jsof_pkg::PH_SOF_HT_LO;
        end
        jsof_pkg::PH_SOF_HT_LO: begin
          res_valid         = 1'b1;
          res.found         = 1'b1;
          res.frame_height  = {hup_r, b};
          res.height_offset = off_ext[jsof_pkg::OFFSET_W-1:0];
        end
        default: res_valid = 1'b1;
      endcase
      // buffer ends undecided: not found
      if (in_data.last_byte) res_valid = 1'b1;
    end

    if (res_valid) decided_nxt = 1'b1;

    if (in_data.last_byte) begin
      phase_nxt   = jsof_pkg::PH_SOI_FF;
      pos_nxt     = '0;
      skip_nxt    = '0;
      hup_nxt     = '0;
      decided_nxt = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (in_fire) begin
      out_valid_nxt = res_valid;
      if (res_valid) out_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= jsof_pkg::PH_SOI_FF;
      pos_r       <= '0;
      skip_r      <= '0;
      hup_r       <= '0;
      decided_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        skip_r    <= skip_nxt;
        hup_r     <= hup_nxt;
        decided_r <= decided_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== src/jsof_checker.sv =====
module jsof_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input jsof_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input jsof_pkg::out_t out_data
);

  // Held result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Back-pressure only comes from a pending result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // Not-found results carry zero fields.
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.frame_height == '0 &&
                                     out_data.height_offset == '0)
    else $error("not-found result with nonzero fields");

  // No result right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The first byte after a buffer ends can't produce found=1 next cycle.
  a_no_early_found: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_byte ##1
    in_valid && !in_stall |=> !(out_valid && out_data.found))
    else $error("found reported on first byte of a buffer");

endmodule

bind jpeg_sof_height_finder jsof_checker u_jsof_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
